// ===== design/bsc_pkg.sv =====
// bsc_pkg: shared types and constants of the beat synced clock and reset generator
// used by every module of the block; depends on nothing

package bsc_pkg;

  localparam int PULSE_W = 20;
  localparam int PPB_W   = 5;
  localparam int SWIN_W  = 16;
  localparam int BEATS_W = 48;
  localparam int PHASE_W = 20;
  localparam int TEMPO_W = 18;
  localparam int MODE_W  = 2;

  localparam int PT_W = PULSE_W + TEMPO_W;
  localparam int PP_W = PT_W + PPB_W;

  // 60 s * 1e6 us * 256 = 2^16 * 234375
  localparam int            K_SHIFT = 16;
  localparam int            K_W     = 18;
  localparam logic [K_W-1:0] K_ODD  = 18'd234375;

  // start window is given with 16 fraction bits
  localparam int SWIN_FRAC = 16;

  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CUED    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd2;

  localparam int               REG_IDX_W           = 2;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_LEN       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PULSES_PER_BEAT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_WINDOW    = 2'd2;

  localparam logic [PULSE_W-1:0] PULSE_LEN_RST = 20'd30000;
  localparam logic [PPB_W-1:0]   PPB_RST       = 5'd4;
  localparam logic [SWIN_W-1:0]  SWIN_RST      = 16'd655;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_len;
    logic [PPB_W-1:0]   ppb;
    logic [SWIN_W-1:0]  start_window;
  } cfg_t;

  typedef struct packed {
    logic press;
    logic neg;
    logic half;
    logic win;
    logic clk_hit;
    logic rst_hit;
  } item_t;

endpackage

// ===== design/bsc_cfg.sv =====
// bsc_cfg: configuration register file of the generator
// depends on bsc_pkg

module bsc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [bsc_pkg::PULSE_W-1:0]      cfg_wdata,
  output bsc_pkg::cfg_t                    cfg_o
);

  bsc_pkg::cfg_t cfg_r;
  bsc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bsc_pkg::REG_PULSE_LEN:       cfg_nxt.pulse_len    = cfg_wdata;
        bsc_pkg::REG_PULSES_PER_BEAT: cfg_nxt.ppb          = cfg_wdata[bsc_pkg::PPB_W-1:0];
        bsc_pkg::REG_START_WINDOW:    cfg_nxt.start_window = cfg_wdata[bsc_pkg::SWIN_W-1:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_len    <= bsc_pkg::PULSE_LEN_RST;
      cfg_r.ppb          <= bsc_pkg::PPB_RST;
      cfg_r.start_window <= bsc_pkg::SWIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/bsc_front.sv =====
// bsc_front: three-stage front end that takes ticks and works out the pulse window tests
// depends on bsc_pkg; feeds bsc_fifo

module bsc_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsc_pkg::cfg_t                cfg_i,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_press,
  input  logic [bsc_pkg::BEATS_W-1:0]  in_beats,
  input  logic [bsc_pkg::PHASE_W-1:0]  in_phase,
  input  logic [bsc_pkg::TEMPO_W-1:0]  in_tempo,
  output logic                         q_valid,
  input  logic                         q_ready,
  output bsc_pkg::item_t               q_item
);

  localparam int WIN_L_W    = bsc_pkg::PHASE_W + bsc_pkg::SWIN_FRAC;
  localparam int WIN_R_W    = bsc_pkg::SWIN_W + FRAC_BITS;
  localparam int WIN_CMP_W  = (WIN_L_W > WIN_R_W) ? WIN_L_W : WIN_R_W;
  localparam int FPROD_W    = FRAC_BITS + bsc_pkg::PPB_W;
  localparam int LHS_C_W    = FRAC_BITS + bsc_pkg::K_W;
  localparam int LHS_R_W    = bsc_pkg::PHASE_W + bsc_pkg::K_W;
  localparam int CLK_L_W    = LHS_C_W + bsc_pkg::K_SHIFT;
  localparam int CLK_R_W    = bsc_pkg::PP_W + FRAC_BITS;
  localparam int CLK_CMP_W  = (CLK_L_W > CLK_R_W) ? CLK_L_W : CLK_R_W;
  localparam int RST_L_W    = LHS_R_W + bsc_pkg::K_SHIFT;
  localparam int RST_R_W    = bsc_pkg::PT_W + FRAC_BITS;
  localparam int RST_CMP_W  = (RST_L_W > RST_R_W) ? RST_L_W : RST_R_W;

  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r;

  logic [bsc_pkg::BEATS_W-1:0] mag;
  logic                        win_c;
  logic [bsc_pkg::PT_W-1:0]    pt_c;
  logic [FPROD_W-1:0]          fprod_c;
  logic [bsc_pkg::PP_W-1:0]    pp_c;
  logic [LHS_R_W-1:0]          lhs_r_c;
  logic [LHS_C_W-1:0]          lhs_c_c;

  logic                        s1_press_r, s1_neg_r, s1_half_r, s1_win_r;
  logic [FRAC_BITS-1:0]        s1_mag_lo_r;
  logic [bsc_pkg::PT_W-1:0]    s1_pt_r;
  logic [bsc_pkg::PHASE_W-1:0] s1_phase_r;

  logic                        s2_press_r, s2_neg_r, s2_half_r, s2_win_r;
  logic [FRAC_BITS-1:0]        s2_frac_r;
  logic [bsc_pkg::PP_W-1:0]    s2_pp_r;
  logic [bsc_pkg::PT_W-1:0]    s2_pt_r;
  logic [LHS_R_W-1:0]          s2_lhs_r_r;

  logic                        s3_press_r, s3_neg_r, s3_half_r, s3_win_r;
  logic [LHS_C_W-1:0]          s3_lhs_c_r;
  logic [bsc_pkg::PP_W-1:0]    s3_pp_r;
  logic [bsc_pkg::PT_W-1:0]    s3_pt_r;
  logic [LHS_R_W-1:0]          s3_lhs_r_r;

  assign adv      = !s3_v_r || q_ready;
  assign in_ready = adv;
  assign q_valid  = s3_v_r;

  // stage 1: magnitude, start window, pulse length times tempo
  assign mag   = in_beats[bsc_pkg::BEATS_W-1] ? (~in_beats + bsc_pkg::BEATS_W'(1)) : in_beats;
  assign win_c = WIN_CMP_W'({in_phase, {bsc_pkg::SWIN_FRAC{1'b0}}})
              <= WIN_CMP_W'({cfg_i.start_window, {FRAC_BITS{1'b0}}});
  assign pt_c  = bsc_pkg::PT_W'(cfg_i.pulse_len) * bsc_pkg::PT_W'(in_tempo);

  // stage 2: division fraction, clock threshold, reset left side
  assign fprod_c = FPROD_W'(s1_mag_lo_r) * FPROD_W'(cfg_i.ppb);
  assign pp_c    = bsc_pkg::PP_W'(s1_pt_r) * bsc_pkg::PP_W'(cfg_i.ppb);
  assign lhs_r_c = LHS_R_W'(s1_phase_r) * LHS_R_W'(bsc_pkg::K_ODD);

  // stage 3: clock left side
  assign lhs_c_c = LHS_C_W'(s2_frac_r) * LHS_C_W'(bsc_pkg::K_ODD);

  always_comb begin
    q_item.press   = s3_press_r;
    q_item.neg     = s3_neg_r;
    q_item.half    = s3_half_r;
    q_item.win     = s3_win_r;
    q_item.clk_hit = CLK_CMP_W'({s3_lhs_c_r, {bsc_pkg::K_SHIFT{1'b0}}})
                  <= CLK_CMP_W'({s3_pp_r, {FRAC_BITS{1'b0}}});
    q_item.rst_hit = RST_CMP_W'({s3_lhs_r_r, {bsc_pkg::K_SHIFT{1'b0}}})
                  <= RST_CMP_W'({s3_pt_r, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_press_r  <= in_press;
      s1_neg_r    <= in_beats[bsc_pkg::BEATS_W-1];
      s1_half_r   <= mag[FRAC_BITS-1];
      s1_win_r    <= win_c;
      s1_mag_lo_r <= mag[FRAC_BITS-1:0];
      s1_pt_r     <= pt_c;
      s1_phase_r  <= in_phase;

      s2_press_r  <= s1_press_r;
      s2_neg_r    <= s1_neg_r;
      s2_half_r   <= s1_half_r;
      s2_win_r    <= s1_win_r;
      s2_frac_r   <= fprod_c[FRAC_BITS-1:0];
      s2_pp_r     <= pp_c;
      s2_pt_r     <= s1_pt_r;
      s2_lhs_r_r  <= lhs_r_c;

      s3_press_r  <= s2_press_r;
      s3_neg_r    <= s2_neg_r;
      s3_half_r   <= s2_half_r;
      s3_win_r    <= s2_win_r;
      s3_lhs_c_r  <= lhs_c_c;
      s3_pp_r     <= s2_pp_r;
      s3_pt_r     <= s2_pt_r;
      s3_lhs_r_r  <= s2_lhs_r_r;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !q_ready) |=> s3_v_r)
    else $error("front dropped a stalled transaction");
`endif

endmodule

// ===== design/bsc_fifo.sv =====
// bsc_fifo: short queue of classified ticks between front and back
// depends on bsc_pkg

module bsc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  bsc_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bsc_pkg::item_t pop_item
);

  localparam logic [bsc_pkg::QPTR_W:0] FULL = (bsc_pkg::QPTR_W + 1)'(bsc_pkg::QUEUE_DEPTH);

  bsc_pkg::item_t mem_r [bsc_pkg::QUEUE_DEPTH];
  logic [bsc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [bsc_pkg::QPTR_W:0]   count_r;
  logic push, pop;

  assign push_ready = count_r != FULL;
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + bsc_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + bsc_pkg::QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + (bsc_pkg::QPTR_W + 1)'(1);
      else if (pop && !push) count_r <= count_r - (bsc_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("queue count beyond depth");
  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + (bsc_pkg::QPTR_W + 1)'(1))
    else $error("queue count missed a push");
`endif

endmodule

// ===== design/bsc_back.sv =====
// bsc_back: run mode sequencer and output register of the generator
// depends on bsc_pkg; fed by bsc_fifo

module bsc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  bsc_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_clock,
  output logic                         out_reset,
  output logic                         out_playing,
  output logic [bsc_pkg::MODE_W-1:0]   out_run_state
);

  logic [bsc_pkg::MODE_W-1:0] mode_r, mode_nxt, mode_pressed;
  logic out_valid_r;
  logic clock_r, reset_r, playing_r;
  logic clock_nxt, reset_nxt, playing_nxt;
  logic pop;

  assign q_ready       = !out_valid_r || out_ready;
  assign pop           = q_valid && q_ready;
  assign out_valid     = out_valid_r;
  assign out_clock     = clock_r;
  assign out_reset     = reset_r;
  assign out_playing   = playing_r;
  assign out_run_state = mode_r;

  always_comb begin
    mode_pressed = mode_r;
    if (q_item.press) begin
      mode_pressed = (mode_r == bsc_pkg::MODE_STOPPED) ? bsc_pkg::MODE_CUED
                                                        : bsc_pkg::MODE_STOPPED;
    end
    mode_nxt    = mode_pressed;
    clock_nxt   = 1'b0;
    reset_nxt   = 1'b0;
    playing_nxt = 1'b0;
    unique case (mode_pressed)
      bsc_pkg::MODE_CUED: begin
        playing_nxt = !q_item.half;
        if (q_item.win) mode_nxt = bsc_pkg::MODE_PLAYING;
      end
      bsc_pkg::MODE_PLAYING: begin
        playing_nxt = 1'b1;
        clock_nxt   = q_item.neg || q_item.clk_hit;
        reset_nxt   = q_item.rst_hit;
      end
      default: mode_nxt = bsc_pkg::MODE_STOPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bsc_pkg::MODE_STOPPED;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) mode_r <= mode_nxt;
      if (q_ready) out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      clock_r   <= clock_nxt;
      reset_r   <= reset_nxt;
      playing_r <= playing_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stop_press: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.press && mode_r != bsc_pkg::MODE_STOPPED) |=>
      (out_run_state == bsc_pkg::MODE_STOPPED && !out_clock && !out_reset && !out_playing))
    else $error("stopping press left a line high");
  a_cue_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_item.press && mode_r == bsc_pkg::MODE_CUED && q_item.win) |=>
      (out_run_state == bsc_pkg::MODE_PLAYING && !out_clock && !out_reset))
    else $error("start tick showed playing outputs");
`endif

endmodule

// ===== design/beat_synced_clock_reset_gen.sv =====
// Beat synced clock and reset generator. One tick (press, beat position, phrase phase,
// tempo) is taken per cycle at most and its result leaves from the output register once it
// has passed the front end and the queue; one tick per cycle is sustained as long as results
// are taken. The path runs through the three-stage multiply and compare front end, the
// four-entry queue and the run mode register in the back end, which advances once per
// tick. FRAC_BITS (8 to 24) is the number of fraction bits of beats and phase.
// depends on bsc_pkg, bsc_cfg, bsc_front, bsc_fifo, bsc_back

module beat_synced_clock_reset_gen #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [87:0]                   in_tdata,   // press, beats, phase, tempo, zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // clock_out, reset_out, playing_out,
                                                    // run_state, zero pad
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bsc_pkg::PULSE_W-1:0]   cfg_wdata
);

  bsc_pkg::cfg_t  cfg;
  bsc_pkg::item_t f_item, b_item;
  logic f_valid, f_ready, b_valid, b_ready;
  logic o_clock, o_reset, o_playing;
  logic [bsc_pkg::MODE_W-1:0] o_run_state;

  bsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  bsc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_press (in_tdata[0]),
    .in_beats (in_tdata[48:1]),
    .in_phase (in_tdata[68:49]),
    .in_tempo (in_tdata[86:69]),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  bsc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  bsc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_item        (b_item),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_clock     (o_clock),
    .out_reset     (o_reset),
    .out_playing   (o_playing),
    .out_run_state (o_run_state)
  );

  assign out_tdata = {3'b000, o_run_state, o_playing, o_reset, o_clock};

endmodule

// ===== tb/tb_beat_synced_clock_reset_gen.sv =====
`timescale 1ns / 1ps
// tb_beat_synced_clock_reset_gen: self-checking bench for the beat synced clock and reset
// generator; a scoreboard class predicts the output lines per tick, plain tasks drive it
// depends on bsc_pkg and beat_synced_clock_reset_gen

module tb_beat_synced_clock_reset_gen;

  localparam int FRAC_BITS = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [bsc_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [63:0] US_TEMPO_SCALE = 64'd15360000000;

  typedef struct packed {
    logic       clock_out;
    logic       reset_out;
    logic       playing_out;
    logic [1:0] run_state;
  } lines_t;

  class line_scoreboard;
    lines_t                        expected_lines[$];
    logic [bsc_pkg::PULSE_W-1:0]   pulse_len;
    logic [bsc_pkg::PPB_W-1:0]     ppb;
    logic [bsc_pkg::SWIN_W-1:0]    start_window;
    logic [bsc_pkg::MODE_W-1:0]    run_mode;
    int                            errors;
    int                            results_seen;

    function new();
      pulse_len    = bsc_pkg::PULSE_LEN_RST;
      ppb          = bsc_pkg::PPB_RST;
      start_window = bsc_pkg::SWIN_RST;
      run_mode     = bsc_pkg::MODE_STOPPED;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void report_mismatch(string what);
      errors++;
      $display("mismatch at result %0d: %s", results_seen, what);
    endfunction

    function void set_reg(logic [bsc_pkg::REG_IDX_W-1:0] idx,
                          logic [bsc_pkg::PULSE_W-1:0] val);
      case (idx)
        bsc_pkg::REG_PULSE_LEN:       pulse_len = val;
        bsc_pkg::REG_PULSES_PER_BEAT: ppb = val[bsc_pkg::PPB_W-1:0];
        bsc_pkg::REG_START_WINDOW:    start_window = val[bsc_pkg::SWIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit under_pulse_len(logic [63:0] x, logic [63:0] p);
      logic [127:0] lhs;
      logic [127:0] rhs;
      lhs = 128'(x) * 128'(US_TEMPO_SCALE);
      rhs = 128'(p) << FRAC_BITS;
      return lhs <= rhs;
    endfunction

    function lines_t predict_lines(logic press, logic [47:0] braw, logic [19:0] phase,
                                   logic [17:0] tempo);
      lines_t      r;
      logic        neg;
      logic [47:0] mag;
      logic [63:0] half;
      logic [63:0] pt;
      logic [63:0] frac;
      r = '0;
      neg = braw[47];
      mag = neg ? (~braw + 48'd1) : braw;
      if (press) begin
        run_mode = (run_mode == bsc_pkg::MODE_STOPPED) ? bsc_pkg::MODE_CUED
                                                       : bsc_pkg::MODE_STOPPED;
      end
      if (run_mode == bsc_pkg::MODE_CUED) begin
        half = (64'(mag) << 1) >> FRAC_BITS;
        r.playing_out = ~half[0];
        if ((64'(phase) << 16) <= (64'(start_window) << FRAC_BITS)) begin
          run_mode = bsc_pkg::MODE_PLAYING;
        end
      end else if (run_mode == bsc_pkg::MODE_PLAYING) begin
        pt = 64'(pulse_len) * 64'(tempo);
        r.playing_out = 1'b1;
        if (neg) begin
          r.clock_out = 1'b1;
        end else begin
          frac = (64'(mag) * 64'(ppb)) & ((64'd1 << FRAC_BITS) - 64'd1);
          r.clock_out = under_pulse_len(frac, pt * 64'(ppb));
        end
        r.reset_out = under_pulse_len(64'(phase), pt);
      end
      r.run_state = run_mode;
      return r;
    endfunction

    function void note_tick(logic [87:0] d);
      expected_lines.push_back(predict_lines(d[0], d[48:1], d[68:49], d[86:69]));
    endfunction

    function void check_lines(logic [7:0] d);
      lines_t e;
      results_seen++;
      if (expected_lines.size() == 0) begin
        report_mismatch("result with no tick pending");
        return;
      end
      e = expected_lines.pop_front();
      if (d[0] !== e.clock_out)
        report_mismatch($sformatf("clock_out %b, expected %b", d[0], e.clock_out));
      if (d[1] !== e.reset_out)
        report_mismatch($sformatf("reset_out %b, expected %b", d[1], e.reset_out));
      if (d[2] !== e.playing_out)
        report_mismatch($sformatf("playing_out %b, expected %b", d[2], e.playing_out));
      if (d[4:3] !== e.run_state)
        report_mismatch($sformatf("run_state %0d, expected %0d", d[4:3], e.run_state));
    endfunction

    function int pending_count();
      return expected_lines.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [87:0]                   in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bsc_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [bsc_pkg::PULSE_W-1:0]   cfg_wdata = '0;

  line_scoreboard sb;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int burst_left = 0;

  beat_synced_clock_reset_gen #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_tick(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_lines(out_tdata);
  end

  initial begin
    int hold_cnt;
    int gap_cnt;
    hold_cnt = 0;
    gap_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else if (gap_cnt > 0) begin
        gap_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) gap_cnt = $urandom_range(1, 11);
      end
    end
  end

  task automatic tick(input logic p, input logic [47:0] b, input logic [19:0] ph,
                      input logic [17:0] t);
    if (!quiet && burst_left == 0 && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_tdata  <= {1'b0, t, ph, b, p};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (sb.pending_count() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bsc_pkg::REG_IDX_W-1:0] idx,
                           input logic [bsc_pkg::PULSE_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(input logic [bsc_pkg::PULSE_W-1:0] pl,
                           input logic [bsc_pkg::PULSE_W-1:0] pb,
                           input logic [bsc_pkg::PULSE_W-1:0] sw);
    write_reg(bsc_pkg::REG_PULSE_LEN, pl);
    write_reg(bsc_pkg::REG_PULSES_PER_BEAT, pb);
    write_reg(bsc_pkg::REG_START_WINDOW, sw);
    write_reg(REG_UNUSED, bsc_pkg::PULSE_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    logic [bsc_pkg::PULSE_W-1:0] pl;
    logic [bsc_pkg::PULSE_W-1:0] pb;
    logic [bsc_pkg::PULSE_W-1:0] sw;
    case ($urandom_range(0, 3))
      0:       pl = bsc_pkg::PULSE_W'($urandom);
      1:       pl = bsc_pkg::PULSE_W'($urandom_range(1, 100000));
      default: pl = bsc_pkg::PULSE_W'($urandom_range(1, 1000000));
    endcase
    pb = ($urandom_range(0, 5) == 0) ? bsc_pkg::PULSE_W'($urandom_range(0, 31))
                                     : bsc_pkg::PULSE_W'($urandom_range(1, 24));
    sw = bsc_pkg::PULSE_W'($urandom_range(0, 65535));
    write_all(pl, pb, sw);
  endtask

  task automatic random_tick();
    logic        p;
    logic [47:0] b;
    logic [19:0] ph;
    logic [17:0] t;
    p = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b = 48'({$urandom, $urandom});
      5, 6:          b = 48'($urandom_range(0, 1 << 24));
      7:             b = -48'($urandom_range(0, 1 << 24));
      8:             b = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      default:       b = {$urandom, 16'h0000};
    endcase
    case ($urandom_range(0, 3))
      0:       ph = 20'($urandom);
      1:       ph = 20'($urandom_range(0, 4096));
      default: ph = 20'($urandom_range(0, 2 * int'(sb.start_window) + 1));
    endcase
    t = $urandom_range(0, 1) ? 18'($urandom_range(15360, 51200)) : 18'($urandom);
    tick(p, b, ph, t);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: stopped, cued blink, start, playing lines, stop paths
    tick(1'b0, 48'h7FFF_FFFF_FFFF, 20'hFFFFF, 18'h3FFFF);
    tick(1'b0, 48'h8000_0000_0000, 20'h00000, 18'h00000);
    tick(1'b1, 48'h0000_0000_8000, 20'hFFFFF, 18'd30720);
    tick(1'b0, 48'h0000_0001_0000, 20'h10000, 18'd30720);
    tick(1'b0, 48'hFFFF_FFFF_8000, 20'd656, 18'd30720);
    tick(1'b0, 48'h0000_0002_0000, 20'd655, 18'd30720);
    tick(1'b0, 48'h0000_0003_0000, 20'd0, 18'd30720);
    tick(1'b0, 48'h0000_0003_4000, 20'h08000, 18'd30720);
    tick(1'b0, 48'h0000_0003_2000, 20'hFFFFF, 18'h3FFFF);
    tick(1'b0, 48'hFFFF_FFFF_1234, 20'd100, 18'd30720);
    tick(1'b0, 48'h8000_0000_0000, 20'd0, 18'd0);
    tick(1'b0, 48'h0000_0000_0001, 20'd1, 18'd0);
    tick(1'b0, 48'h0000_0000_0000, 20'd0, 18'd0);
    tick(1'b1, 48'h0000_0004_0000, 20'd0, 18'd30720);
    tick(1'b1, 48'h0000_0004_0000, 20'hFFFFF, 18'd30720);
    tick(1'b1, 48'h0000_0004_8000, 20'hFFFFF, 18'd30720);
    tick(1'b0, 48'h5555_5555_5555, 20'h55555, 18'h2AAAA);
    end_burst();
    wait_idle();

    // zero pulse length, zero divisions, zero window
    write_all(20'd0, 20'd0, 20'd0);
    tick(1'b1, 48'h0000_0000_0000, 20'd0, 18'd30720);
    tick(1'b0, 48'h0000_0001_2345, 20'd3, 18'd30720);
    tick(1'b0, 48'h0000_0001_0000, 20'd0, 18'd30720);
    end_burst();
    wait_idle();

    // upper extremes
    write_all(20'd1000000, 20'd24, 20'd65535);
    tick(1'b0, 48'h0000_0001_0AAA, 20'hFFFFF, 18'h3FFFF);
    tick(1'b0, 48'hAAAA_AAAA_AAAA, 20'd12345, 18'd30720);
    tick(1'b1, 48'h0000_0002_0000, 20'd0, 18'd30720);
    tick(1'b1, 48'h0000_0000_0000, 20'd65535, 18'd30720);
    tick(1'b1, 48'h0000_0002_0000, 20'd0, 18'd30720);
    end_burst();
    wait_idle();

    for (int ph_i = 0; ph_i < 5; ph_i++) begin
      case (ph_i)
        0:       write_all(20'd1, 20'd1, 20'd0);
        1:       write_all(20'hFFFFF, 20'd31, 20'd65535);
        default: random_config();
      endcase
      if (ph_i == 4) quiet = 1'b1;
      for (int n = 0; n < 126; n++) begin
        if (ph_i == 2 && n == 40) begin
          hold_req = 1'b1;
          burst_left = 40;
        end
        random_tick();
      end
      end_burst();
      wait_idle();
    end

    if (sb.pending_count() > 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_count()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
